/* hdl/aws_pkg.sv */
// ----------------------------------------------------------------------------
// ADC waveform unpack and statistics: shared package
// Field widths, codes, the configuration bundle and the result record.
// ----------------------------------------------------------------------------
package aws_pkg;

  localparam int WORD_W    = 32;
  localparam int HALF_W    = 16;
  localparam int AVAIL_W   = 16;
  localparam int IDX_W     = 11;
  localparam int CNT_W     = 12;
  localparam int SUM_W     = 43;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 11;

  localparam int IN_TDATA_W  = WORD_W + AVAIL_W;
  localparam int RESULT_W    = 2 + IDX_W + WORD_W + IDX_W + WORD_W + IDX_W + SUM_W + SUM_W;
  localparam int OUT_TDATA_W = ((RESULT_W + 7) / 8) * 8;

  localparam logic [IDX_W-1:0] MAX_WORDS = 11'd1024;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_DATA  = 1'b1;

  localparam logic [MODE_W-1:0] MODE_FULL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_HALF = 2'd2;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_SHORT    = 2'd1,
    STATUS_BAD_MODE = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLES_PER_WORD = 2'd0,
    REG_WORDS_PER_EVENT  = 2'd1,
    REG_WINDOW_START     = 2'd2,
    REG_WINDOW_STOP      = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [MODE_W-1:0] samples_per_word;
    logic [IDX_W-1:0]  words_per_event;
    logic [IDX_W-1:0]  window_start;
    logic [IDX_W-1:0]  window_stop;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [IDX_W-1:0]  words_used;
    logic [WORD_W-1:0] max_value;
    logic [IDX_W-1:0]  max_index;
    logic [WORD_W-1:0] min_value;
    logic [IDX_W-1:0]  min_index;
    logic [SUM_W-1:0]  total_sum;
    logic [SUM_W-1:0]  window_sum;
  } result_t;

endpackage

/* hdl/aws_stats.sv */
// ----------------------------------------------------------------------------
// ADC waveform statistics engine
// Holds the event state and folds one word (one or two samples) per step.
// ----------------------------------------------------------------------------
module aws_stats (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  logic                         cmd,
  input  logic [aws_pkg::WORD_W-1:0]   word,
  input  logic [aws_pkg::AVAIL_W-1:0]  avail,
  input  aws_pkg::cfg_t                cfg,
  output logic                         res_valid,
  output aws_pkg::result_t             res
);

  logic                        active;
  logic [aws_pkg::IDX_W-1:0]   words_seen;
  logic [aws_pkg::CNT_W-1:0]   sample_count;
  logic [aws_pkg::WORD_W-1:0]  run_max;
  logic [aws_pkg::IDX_W-1:0]   run_max_idx;
  logic [aws_pkg::WORD_W-1:0]  run_min;
  logic [aws_pkg::IDX_W-1:0]   run_min_idx;
  logic [aws_pkg::SUM_W-1:0]   run_total;
  logic [aws_pkg::SUM_W-1:0]   run_win;
  logic [aws_pkg::IDX_W-1:0]   ev_words;
  logic                        ev_half;
  logic [aws_pkg::IDX_W-1:0]   ev_wstart;
  logic [aws_pkg::IDX_W-1:0]   ev_wstop;

  logic [aws_pkg::IDX_W-1:0]   need;
  logic                        short_cnt;
  logic                        bad_mode;
  logic                        empty_ev;

  logic [aws_pkg::WORD_W-1:0]  samp_lo;
  logic [aws_pkg::WORD_W-1:0]  samp_hi;
  logic [aws_pkg::CNT_W-1:0]   idx_hi;
  logic [aws_pkg::WORD_W-1:0]  max_a, max_next, min_a, min_next;
  logic [aws_pkg::IDX_W-1:0]   max_idx_a, max_idx_next, min_idx_a, min_idx_next;
  logic                        win_lo, win_hi;
  logic [aws_pkg::SUM_W-1:0]   add_lo, add_hi;
  logic [aws_pkg::SUM_W-1:0]   total_next, win_next;
  logic [aws_pkg::CNT_W-1:0]   count_next;
  logic [aws_pkg::IDX_W-1:0]   seen_next;
  logic                        last_word;
  logic                        win_zero;

  always_comb begin
    need      = (cfg.words_per_event > aws_pkg::MAX_WORDS) ? aws_pkg::MAX_WORDS
                                                           : cfg.words_per_event;
    short_cnt = avail < {{(aws_pkg::AVAIL_W-aws_pkg::IDX_W){1'b0}}, need};
    bad_mode  = (cfg.samples_per_word != aws_pkg::MODE_FULL) &&
                (cfg.samples_per_word != aws_pkg::MODE_HALF);
    empty_ev  = (need == '0);
  end

  always_comb begin
    samp_lo = ev_half ? {{(aws_pkg::WORD_W-aws_pkg::HALF_W){1'b0}}, word[aws_pkg::HALF_W-1:0]}
                      : word;
    samp_hi = {{(aws_pkg::WORD_W-aws_pkg::HALF_W){1'b0}},
               word[aws_pkg::WORD_W-1:aws_pkg::HALF_W]};
    idx_hi  = sample_count + 1'b1;

    max_a     = run_max;
    max_idx_a = run_max_idx;
    if ((sample_count == '0) || (samp_lo > run_max)) begin
      max_a     = samp_lo;
      max_idx_a = sample_count[aws_pkg::IDX_W-1:0];
    end
    min_a     = run_min;
    min_idx_a = run_min_idx;
    if ((sample_count == '0) || (samp_lo < run_min)) begin
      min_a     = samp_lo;
      min_idx_a = sample_count[aws_pkg::IDX_W-1:0];
    end

    max_next     = max_a;
    max_idx_next = max_idx_a;
    min_next     = min_a;
    min_idx_next = min_idx_a;
    if (ev_half && (samp_hi > max_a)) begin
      max_next     = samp_hi;
      max_idx_next = idx_hi[aws_pkg::IDX_W-1:0];
    end
    if (ev_half && (samp_hi < min_a)) begin
      min_next     = samp_hi;
      min_idx_next = idx_hi[aws_pkg::IDX_W-1:0];
    end

    win_lo = (sample_count >= {1'b0, ev_wstart}) && (sample_count < {1'b0, ev_wstop});
    win_hi = ev_half && (idx_hi >= {1'b0, ev_wstart}) && (idx_hi < {1'b0, ev_wstop});

    add_lo = {{(aws_pkg::SUM_W-aws_pkg::WORD_W){1'b0}}, samp_lo};
    add_hi = ev_half ? {{(aws_pkg::SUM_W-aws_pkg::WORD_W){1'b0}}, samp_hi} : '0;

    total_next = run_total + add_lo + add_hi;
    win_next   = run_win + (win_lo ? add_lo : '0) + (win_hi ? add_hi : '0);
    count_next = sample_count + (ev_half ? aws_pkg::CNT_W'(2) : aws_pkg::CNT_W'(1));
    seen_next  = words_seen + 1'b1;
    last_word  = seen_next >= ev_words;
    win_zero   = ({1'b0, ev_wstart} >= count_next) || ({1'b0, ev_wstop} >= count_next) ||
                 (ev_wstart > ev_wstop);
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (step && (cmd == aws_pkg::CMD_START)) begin
      res_valid = short_cnt || bad_mode || empty_ev;
      if (short_cnt) begin
        res.status = aws_pkg::STATUS_SHORT;
      end else if (bad_mode) begin
        res.status = aws_pkg::STATUS_BAD_MODE;
      end else begin
        res.status = aws_pkg::STATUS_OK;
      end
    end else if (step && active && last_word) begin
      res_valid      = 1'b1;
      res.status     = aws_pkg::STATUS_OK;
      res.words_used = seen_next;
      res.max_value  = max_next;
      res.max_index  = max_idx_next;
      res.min_value  = min_next;
      res.min_index  = min_idx_next;
      res.total_sum  = total_next;
      res.window_sum = win_zero ? '0 : win_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= 1'b0;
      words_seen   <= '0;
      sample_count <= '0;
      run_max      <= '0;
      run_max_idx  <= '0;
      run_min      <= '0;
      run_min_idx  <= '0;
      run_total    <= '0;
      run_win      <= '0;
      ev_words     <= '0;
      ev_half      <= 1'b0;
      ev_wstart    <= '0;
      ev_wstop     <= '0;
    end else if (step) begin
      if (cmd == aws_pkg::CMD_START) begin
        active       <= !short_cnt && !bad_mode && !empty_ev;
        words_seen   <= '0;
        sample_count <= '0;
        run_max      <= '0;
        run_max_idx  <= '0;
        run_min      <= '0;
        run_min_idx  <= '0;
        run_total    <= '0;
        run_win      <= '0;
        if (!short_cnt && !bad_mode) begin
          ev_words  <= need;
          ev_half   <= (cfg.samples_per_word == aws_pkg::MODE_HALF);
          ev_wstart <= cfg.window_start;
          ev_wstop  <= cfg.window_stop;
        end
      end else if (active) begin
        words_seen   <= seen_next;
        sample_count <= count_next;
        run_max      <= max_next;
        run_max_idx  <= max_idx_next;
        run_min      <= min_next;
        run_min_idx  <= min_idx_next;
        run_total    <= total_next;
        run_win      <= win_next;
        if (last_word) begin
          active <= 1'b0;
        end
      end
    end
  end

endmodule

/* hdl/adc_waveform_unpack_stats_top.sv */
// ----------------------------------------------------------------------------
// ADC waveform unpack and statistics: top level
// Unpacks event words into samples and reports peak, minimum and sums.
// ----------------------------------------------------------------------------
// Usage: the s_ stream carries words; s_tuser low starts an event and
// s_tdata holds the available word count, s_tuser high delivers a data word.
// A start that fails its count or mode check gives an error word at once; a
// good event gives one result word on m_ after its last data word.
// The cfg channel writes the mode, event length and window bounds; it is
// always ready, and values are latched at each start word that passes its
// count and mode checks. An accepted word waits in the input register and
// is processed into the result register when the m_ side is free, which
// raises m_tvalid for a word that completes a result. Throughput is one
// word per cycle in both sample modes while m_ is not stalled; a half-mode
// word folds both of its samples in the same cycle.
// A stalled m_ side holds the result and stops processing; the input
// register fills if it is empty, and s_tready stays low until the result
// is taken.
// Reset clears the event state and loads the configuration defaults.
// ----------------------------------------------------------------------------
module adc_waveform_unpack_stats_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // data_word [31:0], words_available [47:32]
  input  logic [aws_pkg::IN_TDATA_W-1:0]    s_tdata,
  // command
  input  logic                              s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // status [1:0], words_used [12:2], max_value [44:13], max_index [55:45],
  // min_value [87:56], min_index [98:88], total_sum [141:99],
  // window_sum [184:142], zero fill above
  output logic [aws_pkg::OUT_TDATA_W-1:0]   m_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aws_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aws_pkg::CFG_DAT_W-1:0]     cfg_data
);

  aws_pkg::cfg_t                 cfg;
  logic                          in_valid;
  logic                          in_cmd;
  logic [aws_pkg::WORD_W-1:0]    in_word;
  logic [aws_pkg::AVAIL_W-1:0]   in_avail;
  logic                          out_free;
  logic                          advance;
  logic                          res_valid;
  aws_pkg::result_t              res;

  assign cfg_ready = 1'b1;
  assign out_free  = !m_tvalid || m_tready;
  assign advance   = in_valid && out_free;
  assign s_tready  = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.samples_per_word <= aws_pkg::MODE_HALF;
      cfg.words_per_event  <= aws_pkg::MAX_WORDS;
      cfg.window_start     <= '0;
      cfg.window_stop      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (aws_pkg::reg_idx_t'(cfg_index))
        aws_pkg::REG_SAMPLES_PER_WORD: begin
          cfg.samples_per_word <= cfg_data[aws_pkg::MODE_W-1:0];
        end
        aws_pkg::REG_WORDS_PER_EVENT: begin
          cfg.words_per_event <= cfg_data[aws_pkg::IDX_W-1:0];
        end
        aws_pkg::REG_WINDOW_START: begin
          cfg.window_start <= cfg_data[aws_pkg::IDX_W-1:0];
        end
        aws_pkg::REG_WINDOW_STOP: begin
          cfg.window_stop <= cfg_data[aws_pkg::IDX_W-1:0];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_cmd   <= s_tuser;
      in_word  <= s_tdata[aws_pkg::WORD_W-1:0];
      in_avail <= s_tdata[aws_pkg::IN_TDATA_W-1:aws_pkg::WORD_W];
    end
  end

  aws_stats u_stats (
    .clk       (clk),
    .rst       (rst),
    .step      (advance),
    .cmd       (in_cmd),
    .word      (in_word),
    .avail     (in_avail),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= advance && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_tdata <= {{(aws_pkg::OUT_TDATA_W-aws_pkg::RESULT_W){1'b0}},
                  res.window_sum, res.total_sum, res.min_index, res.min_value,
                  res.max_index, res.max_value, res.words_used, res.status};
    end
  end

endmodule

/* hdl/aws_checker.sv */
// ----------------------------------------------------------------------------
// ADC waveform unpack and statistics: port checker
// Watches the result stream of the top level and is bound to it.
// ----------------------------------------------------------------------------
module aws_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [aws_pkg::OUT_TDATA_W-1:0] m_tdata
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Result word valid right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result word changed or dropped.");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[1:0] == aws_pkg::STATUS_OK) ||
                 (m_tdata[1:0] == aws_pkg::STATUS_SHORT) ||
                 (m_tdata[1:0] == aws_pkg::STATUS_BAD_MODE))
    else $error("Result word carries an unknown status.");

  a_error_clear: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] != aws_pkg::STATUS_OK) |-> (m_tdata[aws_pkg::OUT_TDATA_W-1:2] == '0))
    else $error("Error result word has nonzero fields.");

  a_words_bound: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[12:2] <= aws_pkg::MAX_WORDS))
    else $error("Result word reports more words than an event can hold.");

endmodule

bind adc_waveform_unpack_stats_top aws_checker u_aws_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
